// ===== src/rmea_pkg.sv =====
// Package for the rotation-matrix-to-Euler-angles block: widths, CORDIC constants
// and the pipeline record types shared by the cells and the top level.
// No dependencies.
`default_nettype none
package rmea_pkg;
  localparam int EntryWidth = 16;
  localparam int FracBits = EntryWidth - 2;
  localparam int CordicSteps = 20;
  localparam int SqrtSteps = EntryWidth - 1;
  localparam int AccW = 64;
  localparam int ZW = 24;
  localparam int RadW = 2 * EntryWidth;
  localparam int SqW = EntryWidth;
  localparam int CfgW = 15;
  localparam int RollW = 16;
  localparam int PitchW = 15;
  localparam int YawW = 16;
  localparam int RollMax = 25736;
  localparam int PitchMax = 12868;
  localparam int ThreshReset = 16;
  localparam logic signed [ZW-1:0] AngPi = ZW'(3294199);
  localparam int Lanes = 3;
  localparam int LanePitch = 0;
  localparam int LaneRoll = 1;
  localparam int LaneYaw = 2;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = ZW'(823550);
        1: r = ZW'(486170);
        2: r = ZW'(256879);
        3: r = ZW'(130396);
        4: r = ZW'(65451);
        5: r = ZW'(32757);
        6: r = ZW'(16383);
        7: r = ZW'(8192);
        8: r = ZW'(4096);
        9: r = ZW'(2048);
        10: r = ZW'(1024);
        11: r = ZW'(512);
        12: r = ZW'(256);
        13: r = ZW'(128);
        14: r = ZW'(64);
        15: r = ZW'(32);
        16: r = ZW'(16);
        17: r = ZW'(8);
        18: r = ZW'(4);
        19: r = ZW'(2);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [AccW-1:0] x;
    logic signed [AccW-1:0] y;
    logic signed [ZW-1:0]   z;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic                   vld;
    logic                   lock;
    cordic_t [Lanes-1:0]    lane;
  } angle_stage_t;

  typedef struct packed {
    logic                            vld;
    logic [RadW-1:0]                 rem;
    logic [SqW-1:0]                  root;
    logic signed [EntryWidth-1:0]    neg_s;
    logic signed [EntryWidth-1:0]    ax;
    logic signed [EntryWidth-1:0]    ay;
    logic signed [EntryWidth-1:0]    bx;
    logic signed [EntryWidth-1:0]    by;
    logic signed [EntryWidth-1:0]    gx;
    logic signed [EntryWidth:0]      gy;
  } sqrt_stage_t;
endpackage
`default_nettype wire

// ===== src/rotation_matrix_to_euler_angles.sv =====
// Top level: rotation matrix (seven entries) to X-Y-Z Euler angles.
// Uses rmea_pkg, rmea_sqrt_cell and rmea_cordic_cell.
//
//   channel   ports                              handshake
//   request   in_m00..in_m22                     start, busy (always low)
//   result    out_roll/pitch/yaw_angle, lock     out_valid strobe, one cycle
//   config    cfg_we, cfg_pole_threshold         write at any edge with cfg_we
//
// A request is taken every cycle; busy is tied low. A request passes
// SqrtSteps + CordicSteps + 2 = 37 registers: the 15-cell square-root row,
// one capture stage, the 20-cell CORDIC row and the output register.
// rst_n is synchronous; it clears only the valid chain and loads the
// threshold. The receiver cannot stall, so nothing holds.
`default_nettype none
module rotation_matrix_to_euler_angles (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     start,
  output logic                                    busy,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m00,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m01,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m02,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m11,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m12,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m21,
  input  wire  signed [rmea_pkg::EntryWidth-1:0]  in_m22,
  input  wire                                     cfg_we,
  input  wire  [rmea_pkg::CfgW-1:0]               cfg_pole_threshold,
  output logic                                    out_valid,
  output logic signed [rmea_pkg::RollW-1:0]       out_roll_angle,
  output logic signed [rmea_pkg::PitchW-1:0]      out_pitch_angle,
  output logic signed [rmea_pkg::YawW-1:0]        out_yaw_angle,
  output logic                                    out_gimbal_lock
);
  import rmea_pkg::*;

  localparam logic signed [EntryWidth:0] One = (EntryWidth+1)'(1) <<< FracBits;
  localparam int Shift = 60 - EntryWidth;

  logic [CfgW-1:0] thresh_r;
  sqrt_stage_t sq [SqrtSteps+1];
  angle_stage_t an [CordicSteps+1];
  angle_stage_t cap_nxt;
  logic signed [EntryWidth:0] s_ext;
  logic signed [2*EntryWidth+1:0] s_sq;
  logic [SqW-1:0] c_val;
  logic [CfgW+1:0] c14;
  logic lock;
  logic signed [EntryWidth:0] ly [Lanes];
  logic signed [EntryWidth:0] lx [Lanes];
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zp;
  logic signed [ZW-1:0] zy;
  logic out_valid_r;
  logic signed [RollW-1:0] roll_r;
  logic signed [PitchW-1:0] pitch_r;
  logic signed [YawW-1:0] yaw_r;
  logic lock_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= CfgW'(ThreshReset);
    end else if (cfg_we) begin
      thresh_r <= cfg_pole_threshold;
    end
  end

  // Saturate m02 to plus or minus one, form the radicand one - s^2.
  always_comb begin
    s_ext = (EntryWidth+1)'(in_m02);
    if (s_ext > One) begin
      s_ext = One;
    end else if (s_ext < -One) begin
      s_ext = -One;
    end
    s_sq = s_ext * s_ext;
    sq[0].vld = start;
    sq[0].rem = RadW'((One * One) - s_sq);
    sq[0].root = '0;
    sq[0].neg_s = EntryWidth'(-s_ext);
    sq[0].ax = in_m22;
    sq[0].ay = in_m12;
    sq[0].bx = in_m00;
    sq[0].by = in_m01;
    sq[0].gx = in_m11;
    sq[0].gy = -(EntryWidth+1)'(in_m21);
  end

  genvar g;
  generate
    for (g = 0; g < SqrtSteps; g++) begin : g_sqrt
      rmea_sqrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .bit_idx(5'(SqrtSteps - 1 - g)),
        .in_st(sq[g]), .out_st(sq[g+1])
      );
    end
  endgenerate

  // Threshold test and CORDIC pre-rotation into the three lanes.
  function automatic cordic_t pre_rot(input logic signed [EntryWidth:0] y,
                                      input logic signed [EntryWidth:0] x);
    cordic_t r;
    logic signed [AccW-1:0] xs;
    logic signed [AccW-1:0] ys;
    begin
      xs = AccW'(x) <<< Shift;
      ys = AccW'(y) <<< Shift;
      r.zero = (x == 0) && (y == 0);
      r.z = '0;
      if (xs < 0) begin
        r.z = (ys >= 0) ? AngPi : -AngPi;
        xs = -xs;
        ys = -ys;
      end
      r.x = xs;
      r.y = ys;
      return r;
    end
  endfunction

  always_comb begin
    c_val = sq[SqrtSteps].root;
    if (FracBits >= 14) begin
      c14 = (CfgW+2)'(c_val >> (FracBits - 14));
    end else begin
      c14 = (CfgW+2)'(c_val << (14 - FracBits));
    end
    lock = !(c14 > (CfgW+2)'(thresh_r));
    ly[LanePitch] = (EntryWidth+1)'(sq[SqrtSteps].neg_s);
    lx[LanePitch] = (EntryWidth+1)'($signed({1'b0, c_val}));
    if (!lock) begin
      ly[LaneRoll] = (EntryWidth+1)'(sq[SqrtSteps].ay);
      lx[LaneRoll] = (EntryWidth+1)'(sq[SqrtSteps].ax);
    end else begin
      ly[LaneRoll] = sq[SqrtSteps].gy;
      lx[LaneRoll] = (EntryWidth+1)'(sq[SqrtSteps].gx);
    end
    ly[LaneYaw] = (EntryWidth+1)'(sq[SqrtSteps].by);
    lx[LaneYaw] = (EntryWidth+1)'(sq[SqrtSteps].bx);
    cap_nxt.vld = sq[SqrtSteps].vld;
    cap_nxt.lock = lock;
    for (int l = 0; l < Lanes; l++) begin
      cap_nxt.lane[l] = pre_rot(ly[l], lx[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an[0].vld <= 1'b0;
    end else begin
      an[0].vld <= cap_nxt.vld;
    end
    an[0].lock <= cap_nxt.lock;
    an[0].lane <= cap_nxt.lane;
  end

  generate
    for (g = 0; g < CordicSteps; g++) begin : g_cordic
      rmea_cordic_cell u_cell (
        .clk(clk), .rst_n(rst_n), .step(5'(g)),
        .in_st(an[g]), .out_st(an[g+1])
      );
    end
  endgenerate

  // Round the angle to Q3.13 and saturate to each field's range.
  function automatic logic signed [ZW-1:0] to_q13(input cordic_t c, input int lim);
    logic signed [ZW-1:0] q;
    begin
      q = (c.z + ZW'(64)) >>> 7;
      if (c.zero) begin
        q = '0;
      end else if (q > ZW'(lim)) begin
        q = ZW'(lim);
      end else if (q < -ZW'(lim)) begin
        q = -ZW'(lim);
      end
      return q;
    end
  endfunction

  always_comb begin
    zp = to_q13(an[CordicSteps].lane[LanePitch], PitchMax);
    zr = to_q13(an[CordicSteps].lane[LaneRoll], RollMax);
    zy = to_q13(an[CordicSteps].lane[LaneYaw], RollMax);
    if (an[CordicSteps].lock) begin
      zy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= an[CordicSteps].vld;
    end
    roll_r <= RollW'(zr);
    pitch_r <= PitchW'(zp);
    yaw_r <= YawW'(zy);
    lock_r <= an[CordicSteps].lock;
  end

  assign out_valid = out_valid_r;
  assign out_roll_angle = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle = yaw_r;
  assign out_gimbal_lock = lock_r;
endmodule
`default_nettype wire

// ===== src/rmea_sqrt_cell.sv =====
// One bit of the restoring integer square root of 1 - s^2, passing the
// matrix entries along. Uses rmea_pkg.
`default_nettype none
module rmea_sqrt_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire [4:0]              bit_idx,
  input  rmea_pkg::sqrt_stage_t  in_st,
  output rmea_pkg::sqrt_stage_t  out_st
);
  import rmea_pkg::*;

  sqrt_stage_t st_nxt, st_r;
  logic [RadW-1:0] trial;
  logic [RadW-1:0] bitv;

  // Root is built MSB first; trial = (root<<(k+1)) + (1<<2k) compared to remainder.
  always_comb begin
    st_nxt = in_st;
    bitv = RadW'(1) << {bit_idx, 1'b0};
    trial = ((RadW'(in_st.root)) << (bit_idx + 5'd1)) + bitv;
    if (in_st.rem >= trial) begin
      st_nxt.rem = in_st.rem - trial;
      st_nxt.root = in_st.root | (SqW'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else begin
      st_r.vld <= in_st.vld;
    end
    st_r.rem <= st_nxt.rem;
    st_r.root <= st_nxt.root;
    st_r.neg_s <= st_nxt.neg_s;
    st_r.ax <= st_nxt.ax;
    st_r.ay <= st_nxt.ay;
    st_r.bx <= st_nxt.bx;
    st_r.by <= st_nxt.by;
    st_r.gx <= st_nxt.gx;
    st_r.gy <= st_nxt.gy;
  end

  assign out_st = st_r;
endmodule
`default_nettype wire

// ===== src/rmea_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation for all three angle lanes.
// Uses rmea_pkg.
`default_nettype none
module rmea_cordic_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire [4:0]               step,
  input  rmea_pkg::angle_stage_t  in_st,
  output rmea_pkg::angle_stage_t  out_st
);
  import rmea_pkg::*;

  angle_stage_t st_nxt, st_r;
  logic signed [AccW-1:0] dx [Lanes];
  logic signed [AccW-1:0] dy [Lanes];
  logic signed [ZW-1:0] a;

  always_comb begin
    st_nxt = in_st;
    a = atan_entry(int'(step));
    for (int l = 0; l < Lanes; l++) begin
      dx[l] = in_st.lane[l].y >>> step;
      dy[l] = in_st.lane[l].x >>> step;
      if (in_st.lane[l].y > 0) begin
        st_nxt.lane[l].x = in_st.lane[l].x + dx[l];
        st_nxt.lane[l].y = in_st.lane[l].y - dy[l];
        st_nxt.lane[l].z = in_st.lane[l].z + a;
      end else begin
        st_nxt.lane[l].x = in_st.lane[l].x - dx[l];
        st_nxt.lane[l].y = in_st.lane[l].y + dy[l];
        st_nxt.lane[l].z = in_st.lane[l].z - a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else begin
      st_r.vld <= in_st.vld;
    end
    st_r.lock <= st_nxt.lock;
    st_r.lane <= st_nxt.lane;
  end

  assign out_st = st_r;
endmodule
`default_nettype wire

// ===== src/rmea_checker.sv =====
// Port-level checker for rotation_matrix_to_euler_angles, bound to the top.
// Uses rmea_pkg.
`default_nettype none
module rmea_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 busy,
  input wire                                 out_valid,
  input wire signed [rmea_pkg::PitchW-1:0]   out_pitch_angle,
  input wire signed [rmea_pkg::YawW-1:0]     out_yaw_angle,
  input wire signed [rmea_pkg::RollW-1:0]    out_roll_angle,
  input wire                                 out_gimbal_lock
);
  import rmea_pkg::*;

  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gimbal_lock |-> out_yaw_angle == 0) else $error("yaw at lock");
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= PitchW'(PitchMax) && out_pitch_angle >= -PitchW'(PitchMax))
    else $error("pitch range");
  a_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= RollW'(RollMax) && out_roll_angle >= -RollW'(RollMax))
    else $error("roll range");
endmodule

bind rotation_matrix_to_euler_angles rmea_checker u_rmea_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_pitch_angle(out_pitch_angle), .out_yaw_angle(out_yaw_angle),
  .out_roll_angle(out_roll_angle), .out_gimbal_lock(out_gimbal_lock)
);
`default_nettype wire
